[src/srs_pkg.sv]
// shared types, codes and constants of the score repeat sequencer
// no dependencies
package srs_pkg;

    localparam int TOKEN_DEPTH_DEF = 1024;
    localparam int DEST_DEPTH_DEF  = 256;
    localparam int MAX_HOPS_DEF    = 10;

    localparam int TOK_W = 24;
    localparam int DST_W = 30;
    localparam int RC_W  = 8;

    localparam logic [9:0]  NO_DEST  = 10'h3ff;
    localparam logic [7:0]  NO_REF   = 8'hff;
    localparam logic [10:0] CUR_NONE = 11'h7ff;
    localparam logic [10:0] CUR_CAP  = 11'd1024;
    localparam logic [7:0]  RC_FAST  = 8'd100;
    localparam logic [7:0]  RC_MAX   = 8'd255;

    typedef enum logic [1:0] {
        OP_TOKEN = 2'd0,
        OP_DEST  = 2'd1,
        OP_START = 2'd2,
        OP_FETCH = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_REPEAT = 3'd0,
        K_FINE   = 3'd1,
        K_VOLTA  = 3'd2,
        K_JUMP   = 3'd3,
        K_END    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        RES_NOTE = 2'd0,
        RES_END  = 2'd1,
        RES_JUMP = 2'd2
    } t_res;

    typedef struct packed {
        t_op         op;
        logic [9:0]  index;
        logic        is_jump;
        logic [29:0] word;
        logic        switch_on;
    } t_in_item;

    typedef struct packed {
        t_res        result_kind;
        logic [5:0]  duration;
        logic [5:0]  bass_note;
        logic        articulated;
        logic [9:0]  beat_mask;
        logic [9:0]  position;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic write;
        logic start;
        logic fetch;
        logic head;
        logic jread;
        logic exec;
        logic tail;
        logic load;
        t_res res;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic lim_hit;
        logic tok_jump;
        logic exec_end;
        logic hop_last;
    } t_stat;

endpackage

[src/srs_if.sv]
// valid/ready channel interfaces of the score repeat sequencer
// depends on srs_pkg
interface srs_in_if import srs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface srs_out_if import srs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface srs_cfg_if ();
    logic        valid;
    logic        ready;
    logic [10:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/srs_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module srs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[src/srs_datapath.sv]
// datapath: token, destination and run-count stores, cursor and flags
// depends on srs_pkg and srs_ram
module srs_datapath import srs_pkg::*; #(
    parameter int TOKEN_DEPTH = TOKEN_DEPTH_DEF,
    parameter int DEST_DEPTH  = DEST_DEPTH_DEF,
    parameter int MAX_HOPS    = MAX_HOPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_in_item    i_item,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_data,
    output t_stat       o_stat,
    output t_out_item   o_item
);
    localparam int TAW = $clog2(TOKEN_DEPTH);
    localparam int DAW = $clog2(DEST_DEPTH);
    localparam int HW  = $clog2(MAX_HOPS + 1);

    logic [10:0]           r_token_count;
    logic [10:0]           r_cursor;
    logic [9:0]            r_play_until;
    logic [9:0]            r_continue_at;
    logic                  r_repeat_en;
    logic                  r_fine_armed;
    logic                  r_switch;
    logic [HW-1:0]         r_hops;
    logic [DEST_DEPTH-1:0] r_rc_valid;
    t_out_item             r_out;
    t_out_item             n_out;

    logic [10:0] limit;
    logic [10:0] cur_eff;
    logic [10:0] cur_sel;
    logic [10:0] cur_inc;
    logic        pu_hit;

    logic [TOK_W-1:0] tok_q;
    logic [DST_W-1:0] dst_q;
    logic [RC_W-1:0]  rc_q;
    logic             tok_we;
    logic             dst_we;

    t_kind       kind;
    logic        sw;
    logic        fine;
    logic        rep;
    logic [7:0]  dref;
    logic [7:0]  mref;
    logic        has_m;
    logic        has_d;
    logic [7:0]  rc;
    logic [7:0]  rc_step;
    logic [7:0]  rc_new;
    logic        rc_we;
    logic [10:0] dest_to;

    assign limit   = (32'(r_token_count) < TOKEN_DEPTH) ? r_token_count : 11'(TOKEN_DEPTH);
    assign pu_hit  = (r_cursor == {1'b0, r_play_until});
    assign cur_eff = (pu_hit && r_continue_at != NO_DEST) ? {1'b0, r_continue_at} : r_cursor;
    assign cur_sel = i_cmd.head ? cur_eff : r_cursor;
    assign cur_inc = (r_cursor >= CUR_CAP) ? CUR_CAP : r_cursor + 11'd1;

    assign tok_we = i_cmd.write && i_item.op == OP_TOKEN && 32'(i_item.index) < TOKEN_DEPTH;
    assign dst_we = i_cmd.write && i_item.op == OP_DEST && 32'(i_item.index) < DEST_DEPTH;

    // jump token decode, from the held token read
    assign kind    = t_kind'(tok_q[2:0]);
    assign sw      = tok_q[3];
    assign fine    = tok_q[4];
    assign rep     = tok_q[5];
    assign dref    = tok_q[13:6];
    assign mref    = tok_q[21:14];
    assign has_m   = mref != NO_REF && 32'(mref) < DEST_DEPTH;
    assign has_d   = dref != NO_REF && 32'(dref) < DEST_DEPTH;
    assign rc      = r_rc_valid[mref[DAW-1:0]] ? rc_q : 8'd0;
    assign dest_to = {1'b0, dst_q[9:0]};

    srs_ram #(.WIDTH(TOK_W), .DEPTH(TOKEN_DEPTH)) u_tok_ram (
        .i_clk   (i_clk),
        .i_we    (tok_we),
        .i_waddr (i_item.index[TAW-1:0]),
        .i_wdata ({i_item.is_jump, i_item.word[22:0]}),
        .i_re    (i_cmd.head || i_cmd.tail),
        .i_raddr (cur_sel[TAW-1:0]),
        .o_rdata (tok_q)
    );

    srs_ram #(.WIDTH(DST_W), .DEPTH(DEST_DEPTH)) u_dst_ram (
        .i_clk   (i_clk),
        .i_we    (dst_we),
        .i_waddr (i_item.index[DAW-1:0]),
        .i_wdata (i_item.word),
        .i_re    (i_cmd.jread),
        .i_raddr (dref[DAW-1:0]),
        .o_rdata (dst_q)
    );

    srs_ram #(.WIDTH(RC_W), .DEPTH(DEST_DEPTH)) u_rc_ram (
        .i_clk   (i_clk),
        .i_we    (rc_we),
        .i_waddr (mref[DAW-1:0]),
        .i_wdata (rc_new),
        .i_re    (i_cmd.jread),
        .i_raddr (mref[DAW-1:0]),
        .o_rdata (rc_q)
    );

    always_comb begin
        rc_step = (rc < RC_MAX) ? rc + 8'd1 : rc;
        rc_new  = 8'd0;
        rc_we   = 1'b0;
        if (i_cmd.exec && has_m && has_d) begin
            case (kind)
                K_REPEAT, K_VOLTA: begin
                    rc_we  = 1'b1;
                    rc_new = (rc == 8'd0) ? 8'd1 : 8'd0;
                end
                K_JUMP: begin
                    rc_we  = 1'b1;
                    rc_new = (rc_step < RC_FAST) ? rc_step + 8'd1 : rc_step;
                end
                default: begin
                    rc_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_count <= '0;
            r_cursor      <= CUR_NONE;
            r_play_until  <= NO_DEST;
            r_continue_at <= NO_DEST;
            r_repeat_en   <= 1'b1;
            r_fine_armed  <= 1'b0;
            r_hops        <= '0;
            r_rc_valid    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_token_count <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_cursor      <= CUR_NONE;
                r_play_until  <= NO_DEST;
                r_continue_at <= NO_DEST;
                r_repeat_en   <= 1'b1;
                r_fine_armed  <= 1'b0;
                r_rc_valid    <= '0;
            end
            if (i_cmd.fetch) begin
                r_cursor <= (r_cursor == CUR_NONE) ? 11'd0 : cur_inc;
                r_switch <= i_item.switch_on;
                r_hops   <= '0;
            end
            if (i_cmd.head) begin
                r_hops <= r_hops + HW'(1);
                if (pu_hit) begin
                    r_play_until <= NO_DEST;
                    if (r_continue_at != NO_DEST) begin
                        r_cursor      <= cur_eff;
                        r_continue_at <= NO_DEST;
                        r_repeat_en   <= 1'b1;
                    end
                end
            end
            if (rc_we) begin
                r_rc_valid[mref[DAW-1:0]] <= 1'b1;
            end
            if (i_cmd.exec) begin
                case (kind)
                    K_REPEAT: begin
                        if (has_m && has_d) begin
                            r_cursor <= (((!sw && rc == 8'd0) || (sw && !r_switch))
                                         && r_repeat_en) ? dest_to : cur_inc;
                        end
                    end
                    K_FINE: begin
                        // an armed fine ends the song and keeps the cursor
                        if (!r_fine_armed) begin
                            r_cursor <= cur_inc;
                        end
                    end
                    K_VOLTA: begin
                        if (has_m && has_d) begin
                            r_cursor <= (rc != 8'd0) ? dest_to : cur_inc;
                        end
                    end
                    K_JUMP: begin
                        if (has_m && has_d && rc == 8'd0) begin
                            if (fine) begin
                                r_fine_armed <= 1'b1;
                            end
                            r_repeat_en   <= rep;
                            r_cursor      <= dest_to;
                            r_play_until  <= dst_q[19:10];
                            r_continue_at <= dst_q[29:20];
                        end
                    end
                    default: begin
                        r_cursor <= r_cursor;
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_out             = '0;
        n_out.result_kind = i_cmd.res;
        if (i_cmd.res != RES_END) begin
            n_out.position = r_cursor[9:0];
        end
        if (i_cmd.res == RES_NOTE) begin
            n_out.duration    = tok_q[5:0];
            n_out.bass_note   = tok_q[11:6];
            n_out.articulated = tok_q[12];
            n_out.beat_mask   = tok_q[22:13];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= n_out;
        end
    end

    assign o_item          = r_out;
    assign o_stat.lim_hit  = (cur_sel >= limit);
    assign o_stat.tok_jump = tok_q[23];
    assign o_stat.exec_end = (kind == K_END) || (kind == K_FINE && r_fine_armed);
    assign o_stat.hop_last = (32'(r_hops) >= MAX_HOPS);

`ifndef ASSERT_OFF
    a_hops_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hops) <= MAX_HOPS)
        else $error("hop count beyond limit");
    a_rc_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rc_we |-> (i_cmd.exec && has_m))
        else $error("run count written outside jump execution");
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> (r_cursor == CUR_NONE && !r_fine_armed && r_rc_valid == '0))
        else $error("start did not clear run state");
`endif
endmodule

[src/srs_ctrl.sv]
// controller: fetch sequencing state machine and output register handshake
// depends on srs_pkg
module srs_ctrl import srs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_op   i_in_op,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_HEAD, S_TOKW, S_JEXEC, S_TAIL, S_TAILW, S_DONE
    } t_state;

    t_state r_state, n_state;
    t_res   r_res, n_res;
    logic   r_out_valid;
    logic   accept;
    logic   load;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign load       = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_in_op == OP_FETCH) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (i_stat.lim_hit) begin
                    n_res   = RES_END;
                    n_state = S_DONE;
                end else begin
                    n_state = S_TOKW;
                end
            end
            S_TOKW: begin
                if (i_stat.tok_jump) begin
                    n_state = S_JEXEC;
                end else begin
                    n_res   = RES_NOTE;
                    n_state = S_DONE;
                end
            end
            S_JEXEC: begin
                if (i_stat.exec_end) begin
                    n_res   = RES_END;
                    n_state = S_DONE;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                if (i_stat.lim_hit) begin
                    n_res   = RES_END;
                    n_state = S_DONE;
                end else begin
                    n_state = S_TAILW;
                end
            end
            S_TAILW: begin
                if (!i_stat.tok_jump) begin
                    n_res   = RES_NOTE;
                    n_state = S_DONE;
                end else if (i_stat.hop_last) begin
                    n_res   = RES_JUMP;
                    n_state = S_DONE;
                end else begin
                    n_state = S_HEAD;
                end
            end
            S_DONE: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res       <= RES_NOTE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.write = accept && (i_in_op == OP_TOKEN || i_in_op == OP_DEST);
        o_cmd.start = accept && i_in_op == OP_START;
        o_cmd.fetch = accept && i_in_op == OP_FETCH;
        o_cmd.head  = (r_state == S_HEAD);
        // jump operands are read as soon as the token shows a jump
        o_cmd.jread = (r_state == S_TOKW) && i_stat.tok_jump;
        o_cmd.exec  = (r_state == S_JEXEC);
        o_cmd.tail  = (r_state == S_TAIL);
        o_cmd.load  = load;
        o_cmd.res   = r_res;
    end

    assign o_out_valid = r_out_valid;
endmodule

[src/score_repeat_sequencer.sv]
// token, destination and start ops are taken whenever the controller is idle
// a fetch reads its token and, for a jump, the run-count and destination rams, executes the
// jump and reads the next token, for at most MAX_HOPS hops; the result then waits in the output
// register on o_out.ready; each hop is set by the registered reads of the token ram and then
// of the run-count and destination rams; one item is worked at a time
// reset clears token_count, cursor, targets, flags and run-count valid bits;
// token and destination stores are undefined until written
module score_repeat_sequencer import srs_pkg::*; #(
    parameter int TOKEN_DEPTH = TOKEN_DEPTH_DEF,
    parameter int DEST_DEPTH  = DEST_DEPTH_DEF,
    parameter int MAX_HOPS    = MAX_HOPS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    srs_in_if.sink    i_in,
    srs_out_if.source o_out,
    srs_cfg_if.sink   i_cfg
);
    t_cmd  cmd;
    t_stat stat;

    assign i_cfg.ready = 1'b1;

    srs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.data.op),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    srs_datapath #(
        .TOKEN_DEPTH (TOKEN_DEPTH),
        .DEST_DEPTH  (DEST_DEPTH),
        .MAX_HOPS    (MAX_HOPS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_in.data),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .o_stat     (stat),
        .o_item     (o_out.data)
    );
endmodule

[tb/srs_checker.sv]
`timescale 1ns / 100ps
// watches the channels of the score repeat sequencer, predicts each fetch result
// and compares it with what the block returns; depends on srs_pkg and srs_if
module srs_checker import srs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    srs_in_if    i_in,
    srs_out_if   i_out,
    srs_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int N_TOK  = TOKEN_DEPTH_DEF;
    localparam int N_DST  = DEST_DEPTH_DEF;
    localparam int N_HOPS = MAX_HOPS_DEF;

    logic [23:0] score_mem [N_TOK];
    logic [29:0] dest_mem [N_DST];
    logic [7:0]  run_cnt [N_DST];
    logic [10:0] token_count;
    logic [10:0] cursor;
    logic [9:0]  play_until;
    logic [9:0]  continue_at;
    logic        repeat_en;
    logic        fine_armed;

    t_out_item   expected_notes [$];

    function automatic logic [10:0] advance(input logic [10:0] c);
        if (c == CUR_NONE) return 11'd0;
        return (c >= CUR_CAP) ? CUR_CAP : c + 11'd1;
    endfunction

    function automatic void restart_run();
        for (int i = 0; i < N_DST; i++) run_cnt[i] = '0;
        cursor      = CUR_NONE;
        play_until  = NO_DEST;
        continue_at = NO_DEST;
        repeat_en   = 1'b1;
        fine_armed  = 1'b0;
    endfunction

    // mod-two counter of repeats and voltas
    function automatic logic [7:0] toggle_pass(input logic [7:0] v);
        return (v >= 8'd1) ? 8'd0 : v + 8'd1;
    endfunction

    function automatic t_out_item fetch_note(input logic sw_on);
        t_out_item   r;
        logic [10:0] lim;
        logic [23:0] tok;
        logic [7:0]  mref;
        logic [7:0]  dref;
        logic [29:0] dst;
        logic        has_m;
        logic        has_d;
        logic        again;
        int          hops;
        r = '0;
        r.result_kind = RES_END;
        lim = (token_count < CUR_CAP) ? token_count : CUR_CAP;
        cursor = advance(cursor);
        hops = 0;
        do begin
            hops++;
            if (cursor == {1'b0, play_until}) begin
                play_until = NO_DEST;
                if (continue_at != NO_DEST) begin
                    cursor      = {1'b0, continue_at};
                    continue_at = NO_DEST;
                    repeat_en   = 1'b1;
                end
            end
            if (cursor >= lim) return r;
            tok = score_mem[cursor[9:0]];
            if (tok[23]) begin
                dref  = tok[13:6];
                mref  = tok[21:14];
                has_m = (mref != NO_REF);
                has_d = (dref != NO_REF);
                dst   = has_d ? dest_mem[dref] : '0;
                if (tok[2:0] == K_REPEAT && has_m && has_d) begin
                    again = ((!tok[3] && run_cnt[mref] == 8'd0) || (tok[3] && !sw_on))
                            && repeat_en;
                    cursor = again ? {1'b0, dst[9:0]} : advance(cursor);
                    run_cnt[mref] = toggle_pass(run_cnt[mref]);
                end else if (tok[2:0] == K_FINE) begin
                    if (fine_armed) return r;
                    cursor = advance(cursor);
                end else if (tok[2:0] == K_VOLTA && has_m && has_d) begin
                    cursor = (run_cnt[mref] != 8'd0) ? {1'b0, dst[9:0]} : advance(cursor);
                    run_cnt[mref] = toggle_pass(run_cnt[mref]);
                end else if (tok[2:0] == K_JUMP && has_m && has_d) begin
                    if (run_cnt[mref] == 8'd0) begin
                        if (tok[4]) fine_armed = 1'b1;
                        repeat_en   = tok[5];
                        cursor      = {1'b0, dst[9:0]};
                        play_until  = dst[19:10];
                        continue_at = dst[29:20];
                    end
                    if (run_cnt[mref] < RC_MAX) run_cnt[mref]++;
                    if (run_cnt[mref] < RC_FAST) run_cnt[mref]++;
                end else if (tok[2:0] == K_END) begin
                    return r;
                end
                if (cursor >= lim) return r;
                tok = score_mem[cursor[9:0]];
            end
        end while (tok[23] && hops < N_HOPS);
        r.position = cursor[9:0];
        if (tok[23]) begin
            r.result_kind = RES_JUMP;
        end else begin
            r.result_kind = RES_NOTE;
            r.duration    = tok[5:0];
            r.bass_note   = tok[11:6];
            r.articulated = tok[12];
            r.beat_mask   = tok[22:13];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_in_item  it;
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            token_count = '0;
            restart_run();
            expected_notes.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) token_count = i_cfg.data;
            if (i_in.valid && i_in.ready) begin
                it = i_in.data;
                case (it.op)
                    OP_TOKEN: score_mem[it.index] = {it.is_jump, it.word[22:0]};
                    OP_DEST:  if (it.index < N_DST) dest_mem[it.index[7:0]] = it.word;
                    OP_START: restart_run();
                    OP_FETCH: expected_notes.push_back(fetch_note(it.switch_on));
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got = i_out.data;
                if (expected_notes.size() == 0) begin
                    $error("result transfer with no fetch pending");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_notes.pop_front();
                    if (got != want) o_fail_count <= o_fail_count + 1;
                    if (got.result_kind != want.result_kind)
                        $error("result_kind: expected %0d got %0d",
                               want.result_kind, got.result_kind);
                    if (got.duration != want.duration)
                        $error("duration: expected %0d got %0d", want.duration, got.duration);
                    if (got.bass_note != want.bass_note)
                        $error("bass_note: expected %0d got %0d", want.bass_note, got.bass_note);
                    if (got.articulated != want.articulated)
                        $error("articulated: expected %0d got %0d",
                               want.articulated, got.articulated);
                    if (got.beat_mask != want.beat_mask)
                        $error("beat_mask: expected %0d got %0d", want.beat_mask, got.beat_mask);
                    if (got.position != want.position)
                        $error("position: expected %0d got %0d", want.position, got.position);
                end
            end
        end
        o_pending <= expected_notes.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

[tb/tb_score_repeat_sequencer.sv]
`timescale 1ns / 100ps
// stimulus and verdict for the score repeat sequencer; the checker does the comparing
// depends on srs_pkg, srs_if, srs_checker and the block itself
module tb_score_repeat_sequencer;
    import srs_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN       = 5 * MAX_HOPS_DEF + 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   tx_idle = 0;
    int   rx_stall = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   cycles = 0;
    int   fail_count;
    int   pending;
    int   song_len;

    srs_in_if  in_ch ();
    srs_out_if out_ch ();
    srs_cfg_if cfg_ch ();

    score_repeat_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    srs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left    <= 400;
            hold_done    <= 1'b1;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_stall);
        end
    end

    task automatic send(input t_in_item it);
        while ($urandom_range(99) < tx_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_op(input t_op op, input logic [9:0] idx, input logic jmp,
                           input logic [29:0] w, input logic sw);
        t_in_item it;
        it.op        = op;
        it.index     = idx;
        it.is_jump   = jmp;
        it.word      = w;
        it.switch_on = sw;
        send(it);
    endtask

    task automatic fetch(input logic sw);
        send_op(OP_FETCH, 10'($urandom), 1'($urandom), 30'($urandom), sw);
    endtask

    // only between phases, once every fetch has answered
    task automatic set_count(input logic [10:0] n);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= n;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [29:0] jump_word(input logic [2:0] kind, input logic [7:0] mref,
                                              input logic [7:0] dref, input logic sw,
                                              input logic fine, input logic rep);
        return {8'($urandom), mref, dref, rep, fine, sw, kind};
    endfunction

    function automatic logic [9:0] pick_target(input int len);
        int r;
        r = $urandom_range(99);
        if (r < 50) return 10'($urandom_range(len + 2));
        if (r < 80) return NO_DEST;
        return 10'($urandom);
    endfunction

    function automatic logic [7:0] pick_ref();
        int r;
        r = $urandom_range(99);
        if (r < 88) return 8'($urandom_range(7));
        if (r < 94) return NO_REF;
        return 8'($urandom_range(31));
    endfunction

    task automatic write_song(input int len);
        int r;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 72)
                send_op(OP_TOKEN, 10'(i), 1'b0, 30'($urandom), 1'($urandom));
            else
                send_op(OP_TOKEN, 10'(i), 1'b1,
                        jump_word((r < 96) ? 3'($urandom_range(4)) : 3'($urandom),
                                  pick_ref(), pick_ref(), 1'($urandom), 1'($urandom),
                                  1'($urandom)), 1'($urandom));
        end
        for (int d = 0; d < 8; d++)
            send_op(OP_DEST, 10'(d), 1'($urandom),
                    {pick_target(len), pick_target(len), 10'($urandom_range(len + 2))},
                    1'($urandom));
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty song right out of reset
        fetch(1'b0);
        // every slot a song can reach is written once so that no read hits an unwritten entry
        for (int i = 0; i < 64; i++)
            send_op(OP_TOKEN, 10'(i), 1'b0, 30'($urandom), 1'b0);
        for (int i = 1020; i < 1024; i++)
            send_op(OP_TOKEN, 10'(i), 1'b0, 30'($urandom), 1'b0);
        for (int d = 0; d < 32; d++)
            send_op(OP_DEST, 10'(d), 1'b0, {10'd1023, 10'd1023, 10'($urandom_range(15))}, 1'b0);
        set_count(11'd1024);

        // directed song: repeat, volta, jump with fine, fine, end, broken jumps
        send_op(OP_TOKEN, 10'd0, 1'b0, '0, 1'b0);
        send_op(OP_TOKEN, 10'd1023, 1'b0, '1, 1'b1);
        send_op(OP_DEST, 10'd300, 1'b0, '1, 1'b0);
        send_op(OP_DEST, 10'd0, 1'b0, {10'd1023, 10'd1023, 10'd0}, 1'b0);
        send_op(OP_DEST, 10'd1, 1'b0, {10'd8, 10'd5, 10'd3}, 1'b0);
        send_op(OP_DEST, 10'd2, 1'b0, {10'd1023, 10'd1023, 10'd1021}, 1'b0);
        send_op(OP_TOKEN, 10'd1, 1'b1, jump_word(K_REPEAT, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0), 1'b0);
        send_op(OP_TOKEN, 10'd2, 1'b1, jump_word(K_VOLTA, 8'd1, 8'd1, 1'b0, 1'b0, 1'b0), 1'b0);
        send_op(OP_TOKEN, 10'd4, 1'b1, jump_word(K_JUMP, 8'd2, 8'd1, 1'b0, 1'b1, 1'b0), 1'b0);
        send_op(OP_TOKEN, 10'd6, 1'b1, jump_word(K_FINE, 8'd3, 8'd3, 1'b0, 1'b0, 1'b0), 1'b0);
        send_op(OP_TOKEN, 10'd9, 1'b1, jump_word(3'd7, 8'd4, 8'd1, 1'b1, 1'b1, 1'b1), 1'b0);
        send_op(OP_TOKEN, 10'd10, 1'b1, jump_word(K_REPEAT, NO_REF, 8'd0, 1'b1, 1'b0, 1'b0),
                1'b0);
        send_op(OP_TOKEN, 10'd11, 1'b1, jump_word(K_END, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0), 1'b0);
        send_op(OP_START, '0, 1'b0, '0, 1'b0);
        for (int i = 0; i < 10; i++) fetch(i[0]);
        // walk past the last token: sentinel target and cursor cap
        send_op(OP_TOKEN, 10'd0, 1'b1, jump_word(K_JUMP, 8'd5, 8'd2, 1'b1, 1'b0, 1'b1), 1'b0);
        send_op(OP_START, '0, 1'b0, '0, 1'b0);
        for (int i = 0; i < 5; i++) fetch(1'b1);
        set_count(11'd0);
        fetch(1'b0);

        // random songs under each idling mode
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin tx_idle = 0;  rx_stall = 0;  end
                1: begin tx_idle = 78; rx_stall = 0;  end
                2: begin tx_idle = 0;  rx_stall = 78; end
                default: begin tx_idle = 7; rx_stall = 7; end
            endcase
            song_len = (ph == 3) ? 48 : $urandom_range(6, 32);
            write_song(song_len);
            set_count((ph == 5) ? 11'd64 : (ph == 6) ? 11'd0 : 11'(song_len));
            send_op(OP_START, 10'($urandom), 1'($urandom), 30'($urandom), 1'($urandom));
            if (ph == 4) hold_req <= 1'b1;
            for (int i = 0; i < 35; i++) begin
                if ($urandom_range(99) < 4)
                    send_op(OP_START, '0, 1'b0, '0, 1'b0);
                else if ($urandom_range(99) < 4)
                    send_op(OP_DEST, 10'($urandom), 1'b0,
                            {pick_target(song_len), pick_target(song_len),
                             10'($urandom_range(song_len))}, 1'b0);
                else
                    fetch(1'($urandom));
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
